FILE: src/q2e_pkg.sv
// shared types, constants and helpers for the quaternion to euler block
package q2e_pkg;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_QUAT_WIDTH   = 16;
    localparam int ATAN_LEN         = 24;
    localparam int SQ_STAGES        = 31;
    localparam int CW               = 35;

    localparam logic signed [CW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [33:0]   ONE_Q30     = 34'sd1073741824;
    localparam logic signed [CW-1:0] YAW_LIMIT   = 35'sd25736;
    localparam logic signed [CW-1:0] PITCH_LIMIT = 35'sd12868;

    typedef struct packed {
        logic                 zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } lane_t;

    typedef struct packed {
        logic signed [31:0] t0;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
        logic signed [31:0] t3;
        logic signed [31:0] t4;
        logic [60:0]        t2sq;
    } front_t;

    typedef struct packed {
        logic [61:0]        n;
        logic [61:0]        res;
        logic signed [31:0] t0;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
        logic signed [31:0] t3;
        logic signed [31:0] t4;
    } sq_t;

    typedef struct packed {
        lane_t yaw;
        lane_t pitch;
        lane_t roll;
    } cd_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7fffffff;
        if (v < -34'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // atan(2^-i) in q.30, rounded to nearest
    function automatic logic signed [CW-1:0] atan_q30(input int i);
        case (i)
            0:       return 35'sd843314857;
            1:       return 35'sd497837829;
            2:       return 35'sd263043837;
            3:       return 35'sd133525159;
            4:       return 35'sd67021687;
            5:       return 35'sd33543516;
            6:       return 35'sd16775851;
            7:       return 35'sd8388437;
            8:       return 35'sd4194283;
            9:       return 35'sd2097149;
            default: return CW'(35'sd1 <<< (30 - i));
        endcase
    endfunction

    // quadrant fold and zero detect ahead of the first rotation
    function automatic lane_t cordic_init(input logic signed [31:0] y,
                                          input logic signed [31:0] x);
        lane_t r;
        r.zero = (x == 32'sd0) && (y == 32'sd0);
        if (x < 32'sd0)
        begin
            r.x = -CW'(x);
            r.y = -CW'(y);
            r.z = (y >= 32'sd0) ? PI_Q30 : -PI_Q30;
        end
        else
        begin
            r.x = CW'(x);
            r.y = CW'(y);
            r.z = '0;
        end
        return r;
    endfunction

    // q.30 angle to q3.13, round half up, then saturate; a zero vector gives zero
    function automatic logic [15:0] to_q13(input lane_t a,
                                           input logic signed [CW-1:0] lim);
        logic signed [CW-1:0] r;
        r = (a.z + 35'sd65536) >>> 17;
        if (a.zero)
            r = '0;
        else if (r > lim)
            r = lim;
        else if (r < -lim)
            r = -lim;
        return r[15:0];
    endfunction

endpackage

FILE: src/q2e_ifs.sv
// valid/ready channel interfaces for quaternions in and euler angles out
interface q2e_quat_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] quat_w;
    logic signed [W-1:0] quat_x;
    logic signed [W-1:0] quat_y;
    logic signed [W-1:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_euler_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] yaw_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] roll_angle;
    modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
    modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

FILE: src/quaternion_to_euler_321.sv
// throughput: one quaternion per cycle while the skid entry is empty, set by the
// fully pipelined sqrt and cordic cell rows
// a two-entry output stage (output register plus skid) lets input continue while
// a result waits; the pipeline freezes only once both entries are full
// reset: asynchronous active-low rst_n clears all valid bits; payload is not reset
module quaternion_to_euler_321 #(
    parameter int CORDIC_STEPS = q2e_pkg::DEF_CORDIC_STEPS,
    parameter int QUAT_WIDTH   = q2e_pkg::DEF_QUAT_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    q2e_quat_if.sink     quat_in,
    q2e_euler_if.source  euler_out
);
    // table length caps the rotation count
    localparam int STEPS = (CORDIC_STEPS > q2e_pkg::ATAN_LEN) ? q2e_pkg::ATAN_LEN
                                                              : CORDIC_STEPS;

    logic en;
    logic skid_valid_reg;

    // whole pipeline advances while the skid entry is free
    assign en            = !skid_valid_reg;
    assign quat_in.ready = en;

    // front end: products, arguments, pitch square
    q2e_pkg::front_t front;
    logic            front_valid;

    q2e_front #(.QUAT_WIDTH(QUAT_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (quat_in.valid),
        .quat_w    (quat_in.quat_w),
        .quat_x    (quat_in.quat_x),
        .quat_y    (quat_in.quat_y),
        .quat_z    (quat_in.quat_z),
        .out       (front),
        .out_valid (front_valid)
    );

    // sqrt row: n = (1 - t2^2) << 30, one result bit per cell
    q2e_pkg::sq_t sq_chain [q2e_pkg::SQ_STAGES + 1];
    logic         sq_valid [q2e_pkg::SQ_STAGES + 1];
    logic [30:0]  cos_term;

    assign cos_term        = 31'd1073741824 - 31'(front.t2sq[60:30]);
    assign sq_chain[0].n   = {1'b0, cos_term, 30'd0};
    assign sq_chain[0].res = '0;
    assign sq_chain[0].t0  = front.t0;
    assign sq_chain[0].t1  = front.t1;
    assign sq_chain[0].t2  = front.t2;
    assign sq_chain[0].t3  = front.t3;
    assign sq_chain[0].t4  = front.t4;
    assign sq_valid[0]     = front_valid;

    for (genvar k = 0; k < q2e_pkg::SQ_STAGES; k++)
    begin : g_sqrt
        q2e_sqrt_cell #(.K(q2e_pkg::SQ_STAGES - 1 - k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in        (sq_chain[k]),
            .in_valid  (sq_valid[k]),
            .out       (sq_chain[k+1]),
            .out_valid (sq_valid[k+1])
        );
    end

    // cordic row: quadrant fold then STEPS rotation cells
    q2e_pkg::sq_t sq_last;
    q2e_pkg::cd_t cd_chain [STEPS + 1];
    logic         cd_valid [STEPS + 1];

    assign sq_last            = sq_chain[q2e_pkg::SQ_STAGES];
    assign cd_chain[0].roll   = q2e_pkg::cordic_init(sq_last.t0, sq_last.t1);
    assign cd_chain[0].pitch  = q2e_pkg::cordic_init(sq_last.t2,
                                    $signed({1'b0, sq_last.res[30:0]}));
    assign cd_chain[0].yaw    = q2e_pkg::cordic_init(sq_last.t3, sq_last.t4);
    assign cd_valid[0]        = sq_valid[q2e_pkg::SQ_STAGES];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cordic
        q2e_cordic_cell #(.I(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in        (cd_chain[i]),
            .in_valid  (cd_valid[i]),
            .out       (cd_chain[i+1]),
            .out_valid (cd_valid[i+1])
        );
    end

    // rounding to q3.13 and the two-entry output stage
    logic [15:0] yaw_q, pitch_q, roll_q;
    logic        pipe_valid;

    assign yaw_q      = q2e_pkg::to_q13(cd_chain[STEPS].yaw, q2e_pkg::YAW_LIMIT);
    assign pitch_q    = q2e_pkg::to_q13(cd_chain[STEPS].pitch, q2e_pkg::PITCH_LIMIT);
    assign roll_q     = q2e_pkg::to_q13(cd_chain[STEPS].roll, q2e_pkg::YAW_LIMIT);
    assign pipe_valid = cd_valid[STEPS];

    logic        out_valid_reg;
    logic [15:0] out_yaw_reg, out_roll_reg, skid_yaw_reg, skid_roll_reg;
    logic [14:0] out_pitch_reg, skid_pitch_reg;
    logic        load_out, load_skid, take_skid;

    assign take_skid = skid_valid_reg && euler_out.ready;
    assign load_out  = en && pipe_valid && (!out_valid_reg || euler_out.ready);
    assign load_skid = en && pipe_valid && out_valid_reg && !euler_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take_skid)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (load_skid)
        begin
            skid_valid_reg <= 1'b1;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (euler_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_skid)
        begin
            out_yaw_reg   <= skid_yaw_reg;
            out_pitch_reg <= skid_pitch_reg;
            out_roll_reg  <= skid_roll_reg;
        end
        else if (load_out)
        begin
            out_yaw_reg   <= yaw_q;
            out_pitch_reg <= pitch_q[14:0];
            out_roll_reg  <= roll_q;
        end
        if (load_skid)
        begin
            skid_yaw_reg   <= yaw_q;
            skid_pitch_reg <= pitch_q[14:0];
            skid_roll_reg  <= roll_q;
        end
    end

    assign euler_out.valid       = out_valid_reg;
    assign euler_out.yaw_angle   = out_yaw_reg;
    assign euler_out.pitch_angle = out_pitch_reg;
    assign euler_out.roll_angle  = out_roll_reg;

    // skid entry is only ever filled behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // skid entry holds until the output transfer drains it
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !euler_out.ready |=> skid_valid_reg)
        else $error("skid entry lost without transfer");

    // pitch stays within plus or minus pi/2
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($signed(out_pitch_reg) <= 15'sd12868
                           && $signed(out_pitch_reg) >= -15'sd12868))
        else $error("pitch out of range");

    // yaw and roll stay within plus or minus pi
    a_yaw_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($signed(out_yaw_reg) <= 16'sd25736
                           && $signed(out_yaw_reg) >= -16'sd25736
                           && $signed(out_roll_reg) <= 16'sd25736
                           && $signed(out_roll_reg) >= -16'sd25736))
        else $error("yaw or roll out of range");
endmodule

FILE: src/q2e_front.sv
// products, saturated atan2 arguments and the pitch argument square
module q2e_front #(
    parameter int QUAT_WIDTH = q2e_pkg::DEF_QUAT_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [QUAT_WIDTH-1:0] quat_w,
    input  logic signed [QUAT_WIDTH-1:0] quat_x,
    input  logic signed [QUAT_WIDTH-1:0] quat_y,
    input  logic signed [QUAT_WIDTH-1:0] quat_z,
    output q2e_pkg::front_t              out,
    output logic                         out_valid
);
    logic signed [QUAT_WIDTH-1:0] raw [4];
    logic signed [15:0]           q [4];

    assign raw[0] = quat_w;
    assign raw[1] = quat_x;
    assign raw[2] = quat_y;
    assign raw[3] = quat_z;

    // bring each component to q1.15
    for (genvar g = 0; g < 4; g++)
    begin : g_load
        if (QUAT_WIDTH >= 16)
        begin : g_down
            assign q[g] = 16'(raw[g] >>> (QUAT_WIDTH - 16));
        end
        else
        begin : g_up
            assign q[g] = {raw[g], {(16 - QUAT_WIDTH){1'b0}}};
        end
    end

    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg;
    logic signed [31:0] wz_reg, xy_reg, zz_reg;
    logic signed [31:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [31:0] t2_next;
    logic [2:0]         valid_reg;
    q2e_pkg::front_t    out_reg;
    logic signed [63:0] sq_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_comb
    begin
        t2_next = q2e_pkg::sat32((34'(wy_reg) - 34'(zx_reg)) <<< 1);
        if (t2_next > 32'sd1073741824)
            t2_next = 32'sd1073741824;
        else if (t2_next < -32'sd1073741824)
            t2_next = -32'sd1073741824;
    end

    assign sq_full = t2_reg * t2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= q[0] * q[1];
            yz_reg <= q[2] * q[3];
            xx_reg <= q[1] * q[1];
            yy_reg <= q[2] * q[2];
            wy_reg <= q[0] * q[2];
            zx_reg <= q[3] * q[1];
            wz_reg <= q[0] * q[3];
            xy_reg <= q[1] * q[2];
            zz_reg <= q[3] * q[3];
            t0_reg <= q2e_pkg::sat32((34'(wx_reg) + 34'(yz_reg)) <<< 1);
            t1_reg <= q2e_pkg::sat32(q2e_pkg::ONE_Q30 - ((34'(xx_reg) + 34'(yy_reg)) <<< 1));
            t2_reg <= t2_next;
            t3_reg <= q2e_pkg::sat32((34'(wz_reg) + 34'(xy_reg)) <<< 1);
            t4_reg <= q2e_pkg::sat32(q2e_pkg::ONE_Q30 - ((34'(yy_reg) + 34'(zz_reg)) <<< 1));
            out_reg.t0   <= t0_reg;
            out_reg.t1   <= t1_reg;
            out_reg.t2   <= t2_reg;
            out_reg.t3   <= t3_reg;
            out_reg.t4   <= t4_reg;
            out_reg.t2sq <= sq_full[60:0];
        end
    end

    assign out       = out_reg;
    assign out_valid = valid_reg[2];
endmodule

FILE: src/q2e_sqrt_cell.sv
// one result bit of the floor square root, other arguments ride along
module q2e_sqrt_cell #(
    parameter int K = 30
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  q2e_pkg::sq_t  in,
    input  logic          in_valid,
    output q2e_pkg::sq_t  out,
    output logic          out_valid
);
    localparam logic [61:0] BIT = 62'd1 << (2 * K);

    q2e_pkg::sq_t out_reg, out_next;
    logic         valid_reg;
    logic [61:0]  trial;

    always_comb
    begin
        trial    = in.res + BIT;
        out_next = in;
        if (in.n >= trial)
        begin
            out_next.n   = in.n - trial;
            out_next.res = (in.res >> 1) + BIT;
        end
        else
        begin
            out_next.res = in.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign out       = out_reg;
    assign out_valid = valid_reg;
endmodule

FILE: src/q2e_cordic_cell.sv
// one vectoring rotation for the yaw, pitch and roll lanes
module q2e_cordic_cell #(
    parameter int I = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  q2e_pkg::cd_t  in,
    input  logic          in_valid,
    output q2e_pkg::cd_t  out,
    output logic          out_valid
);
    localparam logic signed [q2e_pkg::CW-1:0] ANG = q2e_pkg::atan_q30(I);

    function automatic q2e_pkg::lane_t rotate(input q2e_pkg::lane_t a);
        q2e_pkg::lane_t r;
        r.zero = a.zero;
        if (a.y > 0)
        begin
            r.x = a.x + (a.y >>> I);
            r.y = a.y - (a.x >>> I);
            r.z = a.z + ANG;
        end
        else
        begin
            r.x = a.x - (a.y >>> I);
            r.y = a.y + (a.x >>> I);
            r.z = a.z - ANG;
        end
        return r;
    endfunction

    q2e_pkg::cd_t out_reg;
    logic         valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.yaw   <= rotate(in.yaw);
            out_reg.pitch <= rotate(in.pitch);
            out_reg.roll  <= rotate(in.roll);
        end
    end

    assign out       = out_reg;
    assign out_valid = valid_reg;
endmodule

FILE: bench/tb_quaternion_to_euler_321.sv
// self-checking bench for the quaternion to 3-2-1 euler angle converter
`timescale 1ns / 100ps

module tb_quaternion_to_euler_321;

    localparam int STEPS   = 16;
    localparam int LATENCY = 35 + STEPS;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
    } euler_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    q2e_quat_if #(.W(16)) quat_in ();
    q2e_euler_if          euler_out ();

    quaternion_to_euler_321 #(.CORDIC_STEPS(STEPS), .QUAT_WIDTH(16)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .quat_in   (quat_in.sink),
        .euler_out (euler_out.source)
    );

    always #1 clk = ~clk;

    euler_t angles_due[$];
    int     mismatches = 0;
    int     transfers_in = 0;
    int     transfers_out = 0;
    int     hold_off = 0;        // cycles left in a long receiver stall
    int     stall_mode = 0;      // 0 none, 1 random, 2 pattern

    // angle tables in q.30
    localparam longint ATAN_TAB [0:23] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    localparam longint PI30  = 64'sd3373259426;
    localparam longint UNIT  = 64'sd1073741824;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // vectoring rotation, returns the angle of (xv, yv) in q.30
    function automatic longint vector_angle(longint yv, longint xv);
        longint ang;
        longint nx;
        longint ny;
        ang = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            ang = (yv >= 0) ? PI30 : -PI30;
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            if (yv > 0)
            begin
                nx = xv + (yv >>> i);
                ny = yv - (xv >>> i);
                ang = ang + ATAN_TAB[i];
            end
            else
            begin
                nx = xv - (yv >>> i);
                ny = yv + (xv >>> i);
                ang = ang - ATAN_TAB[i];
            end
            xv = nx;
            yv = ny;
        end
        return ang;
    endfunction

    function automatic longint round_q13(longint ang, longint lim);
        longint r;
        r = (ang + 65536) >>> 17;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic euler_t euler_of(logic signed [15:0] qw, logic signed [15:0] qx,
                                        logic signed [15:0] qy, logic signed [15:0] qz);
        longint w, x, y, z, sr, cr, sp, sy, cy, cp, root;
        euler_t e;
        w = qw; x = qx; y = qy; z = qz;
        sr = clip32(2 * (w * x + y * z));
        cr = clip32(UNIT - 2 * (x * x + y * y));
        sp = clip32(2 * (w * y - z * x));
        sy = clip32(2 * (w * z + x * y));
        cy = clip32(UNIT - 2 * (y * y + z * z));
        if (sp > UNIT)
            sp = UNIT;
        if (sp < -UNIT)
            sp = -UNIT;
        cp = UNIT - ((sp * sp) >>> 30);
        root = int_sqrt(longint'(cp) << 30);
        e.roll  = 16'(round_q13(vector_angle(sr, cr), 25736));
        e.pitch = 15'(round_q13(vector_angle(sp, root), 12868));
        e.yaw   = 16'(round_q13(vector_angle(sy, cy), 25736));
        return e;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 transfers_out, what, got, want);
        mismatches++;
    endtask

    // sends one quaternion and records the expected angles
    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        quat_in.valid  <= 1'b1;
        quat_in.quat_w <= w;
        quat_in.quat_x <= x;
        quat_in.quat_y <= y;
        quat_in.quat_z <= z;
        angles_due.insert(angles_due.size(), euler_of(w, x, y, z));
        @(posedge clk);
        while (!quat_in.ready)
            @(posedge clk);
        transfers_in++;
    endtask

    task automatic idle_sender(int n);
        quat_in.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_results();
        quat_in.valid <= 1'b0;
        @(posedge clk);
        while (angles_due.size() != 0)
            @(posedge clk);
    endtask

    // a unit quaternion from a random direction, occasionally non-unit
    task automatic send_random(bit unit_norm);
        real a, b, c, d, n;
        if (!unit_norm)
        begin
            send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            return;
        end
        a = $urandom_range(0, 65535) - 32768.0;
        b = $urandom_range(0, 65535) - 32768.0;
        c = $urandom_range(0, 65535) - 32768.0;
        d = $urandom_range(0, 65535) - 32768.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
            n = 1.0;
        send_quat(16'($rtoi(a / n * 32767.0)), 16'($rtoi(b / n * 32767.0)),
                  16'($rtoi(c / n * 32767.0)), 16'($rtoi(d / n * 32767.0)));
    endtask

    // receiver ready: long hold-off, random stalls or a partly random pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            euler_out.ready <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            euler_out.ready <= 1'b0;
        end
        else if (stall_mode == 1)
            euler_out.ready <= ($urandom_range(0, 3) != 0);
        else if (stall_mode == 2)
            euler_out.ready <= (transfers_out % 5 != 2) || ($urandom_range(0, 1) == 1);
        else
            euler_out.ready <= 1'b1;
    end

    // checks each result against the oldest expectation
    always @(posedge clk)
    begin
        euler_t want;
        if (rst_n && euler_out.valid && euler_out.ready)
        begin
            transfers_out++;
            if (angles_due.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                want = angles_due.pop_front();
                if (euler_out.yaw_angle !== want.yaw)
                    report_mismatch("yaw", euler_out.yaw_angle, want.yaw);
                if (euler_out.pitch_angle !== want.pitch)
                    report_mismatch("pitch", euler_out.pitch_angle, want.pitch);
                if (euler_out.roll_angle !== want.roll)
                    report_mismatch("roll", euler_out.roll_angle, want.roll);
            end
        end
    end

    // extremes, identity, gimbal lock, zero and saturating inputs
    task automatic test_directed();
        send_quat(16'h7fff, 0, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h5a82, 0, 16'h5a82, 0);
        send_quat(16'h5a82, 0, 16'ha57e, 0);
        send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000);
        send_quat(0, 16'h7fff, 0, 0);
        send_quat(0, 0, 0, 16'h7fff);
        send_quat(0, 0, 16'h7fff, 0);
        send_quat(0, 16'h8000, 0, 0);
        send_quat(16'h8000, 0, 0, 0);
        send_quat(16'h5a82, 16'h5a82, 0, 0);
        send_quat(16'h5a82, 16'ha57e, 0, 0);
        send_quat(16'h5a82, 0, 0, 16'h5a82);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
        send_quat(16'h0001, 16'haaaa, 16'h5555, 16'hffff);
        send_quat(16'h4000, 16'h4000, 16'h4000, 16'hc000);
        drain_results();
    endtask

    // bursty sender against a randomly chosen receiver stall mode
    task automatic test_random_bursts(int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            stall_mode = $urandom_range(0, 2);
            repeat ($urandom_range(1, 40))
            begin
                send_random($urandom_range(0, 9) != 0);
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 12));
        end
        drain_results();
    endtask

    // receiver holds off while the sender keeps offering, pipeline must back up
    task automatic test_backpressure();
        stall_mode = 0;
        hold_off = 3 * LATENCY;
        repeat (LATENCY + 40)
            send_random(1'b1);
        drain_results();
    endtask

    initial
    begin
        quat_in.valid  <= 1'b0;
        quat_in.quat_w <= '0;
        quat_in.quat_x <= '0;
        quat_in.quat_y <= '0;
        quat_in.quat_z <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_bursts(1500);
        stall_mode = 1;
        test_backpressure();

        // let any stray result surface after the last expectation
        repeat (2 * LATENCY) @(posedge clk);
        $display("covered %0d quaternions in, %0d angle sets out, with stalls on both sides",
                 transfers_in, transfers_out);
        if (mismatches == 0 && angles_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout waiting for results");
        $display("Regression FAIL");
        $finish;
    end

endmodule
